[rtl/prlr_pkg.sv]
// Shared types and constants for the pump relay lockout and run-time block.
// Used by prlr_cfg, prlr_core and pump_relay_lockout_runtime_top; depends on nothing.
package prlr_pkg;

  localparam int TimeW = 32;
  localparam int OpW = 3;
  localparam int StatusW = 2;
  localparam int CfgAddrW = 4;

  localparam logic [TimeW-1:0] MinIntervalReset = TimeW'(10000);
  localparam logic [TimeW-1:0] MaxRunReset = TimeW'(1800000);

  typedef enum logic [OpW-1:0] {
    OP_ON          = 3'd0,
    OP_OFF         = 3'd1,
    OP_TOGGLE      = 3'd2,
    OP_RESET_STATS = 3'd3,
    OP_QUERY       = 3'd4
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_EN   = 2'd1,
    ST_INTERVAL = 2'd2
  } status_t;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [1:0] {
    REG_ENABLED      = 2'd0,
    REG_MIN_INTERVAL = 2'd1,
    REG_MAX_RUN      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             enabled;
    logic [TimeW-1:0] min_interval_ms;
    logic [TimeW-1:0] max_run_ms;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic             relay_on;
    logic [TimeW-1:0] activation_count;
    logic [TimeW-1:0] total_run_ms;
    logic [TimeW-1:0] continuous_run_ms;
    logic [TimeW-1:0] since_change_ms;
    logic             over_max_run;
  } result_t;

endpackage

[rtl/prlr_cfg.sv]
// Configuration register file with an APB-style access port.
// Depends on prlr_pkg for the register indexes and the cfg_t bundle.
module prlr_cfg import prlr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled         <= 1'b0;
      cfg.min_interval_ms <= MinIntervalReset;
      cfg.max_run_ms      <= MaxRunReset;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLED:      cfg.enabled         <= pwdata[0];
        REG_MIN_INTERVAL: cfg.min_interval_ms <= pwdata;
        REG_MAX_RUN:      cfg.max_run_ms      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLED:      prdata = {31'd0, cfg.enabled};
      REG_MIN_INTERVAL: prdata = cfg.min_interval_ms;
      REG_MAX_RUN:      prdata = cfg.max_run_ms;
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/prlr_core.sv]
// Relay state, lockout decision and run-time statistics for one command per cycle while fire is high.
// Depends on prlr_pkg for op codes, status codes and the cfg_t and result_t bundles.
module prlr_core import prlr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [OpW-1:0]   op,
  input  logic [TimeW-1:0] now_ms,
  input  cfg_t             cfg,
  output result_t          res
);

  logic             pump_on;
  logic [TimeW-1:0] last_change_time;
  logic [TimeW-1:0] run_start_time;
  logic [TimeW-1:0] accumulated_run;
  logic [TimeW-1:0] activations;

  op_t              op_dec;
  logic             change_op;
  logic             want_on;
  logic             do_change;
  logic             on_next;
  logic             still_on;
  logic [TimeW-1:0] d_run;
  logic [TimeW-1:0] d_chg;
  status_t          status;

  assign op_dec = op_t'(op);
  assign d_run  = now_ms - run_start_time;
  assign d_chg  = now_ms - last_change_time;

  always_comb begin
    change_op = 1'b0;
    want_on   = pump_on;
    case (op_dec)
      OP_ON: begin
        change_op = 1'b1;
        want_on   = 1'b1;
      end
      OP_OFF: begin
        change_op = 1'b1;
        want_on   = 1'b0;
      end
      OP_TOGGLE: begin
        change_op = 1'b1;
        want_on   = !pump_on;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!change_op) begin
      status = ST_OK;
    end else if (!cfg.enabled) begin
      status = ST_NOT_EN;
    end else if (d_chg < cfg.min_interval_ms) begin
      status = ST_INTERVAL;
    end else begin
      status = ST_OK;
    end
  end

  assign do_change = change_op && (status == ST_OK) && (want_on != pump_on);
  assign on_next   = do_change ? want_on : pump_on;
  // A run is still in progress after this command only if it was running before and stays on.
  assign still_on  = on_next && pump_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_on          <= 1'b0;
      last_change_time <= '0;
      run_start_time   <= '0;
      accumulated_run  <= '0;
      activations      <= '0;
    end else if (fire) begin
      if (op_dec == OP_RESET_STATS) begin
        accumulated_run <= '0;
        activations     <= '0;
      end else if (do_change) begin
        pump_on          <= want_on;
        last_change_time <= now_ms;
        if (want_on) begin
          activations    <= activations + TimeW'(1);
          run_start_time <= now_ms;
        end else begin
          accumulated_run <= accumulated_run + d_run;
        end
      end
    end
  end

  // The result is formed from the current state in parallel with the update.
  always_comb begin
    res.status   = status;
    res.relay_on = on_next;
    if (op_dec == OP_RESET_STATS) begin
      res.activation_count = '0;
    end else if (do_change && want_on) begin
      res.activation_count = activations + TimeW'(1);
    end else begin
      res.activation_count = activations;
    end
    res.total_run_ms = ((op_dec == OP_RESET_STATS) ? '0 : accumulated_run)
                     + (pump_on ? d_run : '0);
    res.continuous_run_ms = still_on ? d_run : '0;
    res.since_change_ms   = do_change ? '0 : d_chg;
    res.over_max_run      = still_on && (cfg.max_run_ms != '0) && (d_run > cfg.max_run_ms);
  end

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (rst)
    fire && (status != ST_OK) |=> $stable(pump_on) && $stable(last_change_time))
    else $error("refused command changed the relay state");

  a_turn_on_counts: assert property (@(posedge clk) disable iff (rst)
    fire && do_change && want_on && (op_dec != OP_RESET_STATS)
      |=> pump_on && (activations == $past(activations) + TimeW'(1)))
    else $error("turn-on did not count exactly one activation");

endmodule

[rtl/pump_relay_lockout_runtime_top.sv]
// A command transaction is taken into the input register and processed by the core, and its
// result is captured in the result register, from which the result transaction is sent.
// Throughput: one command per cycle, sustained while the result is not stalled; the relay
// state and statistics update at the same edge that loads the result register from the core.
// A stalled result is held in the result register while the input register takes one more.
// Reset (rst, synchronous) clears both register valids, turns the relay off, zeroes the
// statistics and loads the configuration reset values (disabled, 10000 ms, 1800000 ms).
module pump_relay_lockout_runtime_top import prlr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Command channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OpW-1:0]      op,
  input  logic [TimeW-1:0]    now_ms,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [StatusW-1:0]  status,
  output logic                relay_on,
  output logic [TimeW-1:0]    activation_count,
  output logic [TimeW-1:0]    total_run_ms,
  output logic [TimeW-1:0]    continuous_run_ms,
  output logic [TimeW-1:0]    since_change_ms,
  output logic                over_max_run,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t             cfg;
  result_t          res;

  // Input register: holds one command until the core can process it.
  logic             in_q_valid;
  logic [OpW-1:0]   in_q_op;
  logic [TimeW-1:0] in_q_now;

  // The result register can take a new value when it is empty or being drained.
  logic             advance;
  logic             fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_q_valid && advance;
  // The input register is only blocked when it is full and its command cannot move on.
  assign in_stall = in_q_valid && !advance;

  prlr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prlr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .op     (in_q_op),
    .now_ms (in_q_now),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_op  <= op;
      in_q_now <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status            <= res.status;
      relay_on          <= res.relay_on;
      activation_count  <= res.activation_count;
      total_run_ms      <= res.total_run_ms;
      continuous_run_ms <= res.continuous_run_ms;
      since_change_ms   <= res.since_change_ms;
      over_max_run      <= res.over_max_run;
    end
  end

  // The over-limit flag and a nonzero continuous run only exist while the relay is on.
  a_over_needs_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && over_max_run |-> relay_on)
    else $error("over-limit flag raised with the relay off");

  a_run_needs_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (continuous_run_ms != '0) |-> relay_on)
    else $error("continuous run reported with the relay off");

endmodule
